/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define C8_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define C8_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/c8ic_pkg.sv */
package c8ic_pkg;

    localparam logic [11:0] C_START_PC = 12'h200;
    localparam int          C_FONT_BYTES = 80;

    // item function codes
    localparam logic [1:0] FN_WR   = 2'd0;
    localparam logic [1:0] FN_EXEC = 2'd1;
    localparam logic [1:0] FN_FBRD = 2'd2;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] SYS_CLS = 16'h00E0;
    localparam logic [15:0] SYS_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] FX_GDT  = 8'h07;
    localparam logic [7:0] FX_WKEY = 8'h0A;
    localparam logic [7:0] FX_SDT  = 8'h15;
    localparam logic [7:0] FX_SST  = 8'h18;
    localparam logic [7:0] FX_ADDI = 8'h1E;
    localparam logic [7:0] FX_FONT = 8'h29;
    localparam logic [7:0] FX_BCD  = 8'h33;
    localparam logic [7:0] FX_SAVE = 8'h55;
    localparam logic [7:0] FX_LOAD = 8'h65;

    localparam logic [7:0] C_FONT [C_FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // datapath operation for the current cycle
    typedef enum logic [4:0] {
        DOP_CLR, DOP_TAKE, DOP_WR, DOP_FBRD, DOP_F0, DOP_F1, DOP_F2, DOP_F3,
        DOP_F4, DOP_EXEC, DOP_VF, DOP_D0, DOP_D1, DOP_D2, DOP_D3, DOP_B0,
        DOP_B1, DOP_B2, DOP_SR, DOP_SW, DOP_LR, DOP_LW, DOP_FIN
    } t_dop;

    // follow-up work after the execute step
    typedef enum logic [2:0] {
        CL_SIMPLE, CL_FLAG, CL_DRAW, CL_BCD, CL_SAVE, CL_LOAD
    } t_cls;

    typedef struct packed {
        t_dop op;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic rows_zero;
        logic last_row;
        logic last_cnt;
        logic clr_last;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] f_font(input logic [6:0] a);
        return C_FONT[a];
    endfunction

    function automatic t_cls f_cls(input logic [15:0] op);
        t_cls c;
        c = CL_SIMPLE;
        if (op[15:12] == OP_DRW) begin
            c = CL_DRAW;
        end else if (op[15:12] == OP_ALU) begin
            if (op[3:0] == ALU_ADD || op[3:0] == ALU_SUB || op[3:0] == ALU_SHR ||
                op[3:0] == ALU_SBN || op[3:0] == ALU_SHL) begin
                c = CL_FLAG;
            end
        end else if (op[15:12] == OP_MISC) begin
            if (op[7:0] == FX_BCD) begin
                c = CL_BCD;
            end else if (op[7:0] == FX_SAVE) begin
                c = CL_SAVE;
            end else if (op[7:0] == FX_LOAD) begin
                c = CL_LOAD;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/c8ic_if.sv */
interface c8ic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [15:0] keys;
    logic [7:0]  rand_byte;

    modport source (output valid, func, addr, wdata, keys, rand_byte, input ready);
    modport sink   (input valid, func, addr, wdata, keys, rand_byte, output ready);
endinterface

interface c8ic_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rdata;
    logic [11:0] pc_now;
    logic [15:0] opcode_done;
    logic        key_wait;
    logic        sound_on;
    logic        bad_opcode;

    modport source (output valid, rdata, pc_now, opcode_done, key_wait, sound_on, bad_opcode,
                    input ready);
    modport sink   (input valid, rdata, pc_now, opcode_done, key_wait, sound_on, bad_opcode,
                    output ready);
endinterface

/* rtl/c8ic_ctrl.sv */
module c8ic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_func,
    input  c8ic_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output c8ic_pkg::t_cmd   o_cmd
);

    typedef enum logic [22:0] {
        S_CLR  = 23'h000001,
        S_IDLE = 23'h000002,
        S_WR   = 23'h000004,
        S_FBRD = 23'h000008,
        S_F0   = 23'h000010,
        S_F1   = 23'h000020,
        S_F2   = 23'h000040,
        S_F3   = 23'h000080,
        S_F4   = 23'h000100,
        S_EXEC = 23'h000200,
        S_VF   = 23'h000400,
        S_D0   = 23'h000800,
        S_D1   = 23'h001000,
        S_D2   = 23'h002000,
        S_D3   = 23'h004000,
        S_B0   = 23'h008000,
        S_B1   = 23'h010000,
        S_B2   = 23'h020000,
        S_SR   = 23'h040000,
        S_SW   = 23'h080000,
        S_LR   = 23'h100000,
        S_LW   = 23'h200000,
        S_FIN  = 23'h400000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = c8ic_pkg::DOP_TAKE;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = c8ic_pkg::DOP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.op = c8ic_pkg::DOP_TAKE;
                if (i_in_valid) begin
                    case (i_in_func)
                        c8ic_pkg::FN_WR:   n_state = S_WR;
                        c8ic_pkg::FN_EXEC: n_state = S_F0;
                        c8ic_pkg::FN_FBRD: n_state = S_FBRD;
                        default:           n_state = S_FIN;
                    endcase
                end
            end
            S_WR:   begin o_cmd.op = c8ic_pkg::DOP_WR;   n_state = S_FIN; end
            S_FBRD: begin o_cmd.op = c8ic_pkg::DOP_FBRD; n_state = S_FIN; end
            S_F0:   begin o_cmd.op = c8ic_pkg::DOP_F0;   n_state = S_F1; end
            S_F1:   begin o_cmd.op = c8ic_pkg::DOP_F1;   n_state = S_F2; end
            S_F2:   begin o_cmd.op = c8ic_pkg::DOP_F2;   n_state = S_F3; end
            S_F3:   begin o_cmd.op = c8ic_pkg::DOP_F3;   n_state = S_F4; end
            S_F4:   begin o_cmd.op = c8ic_pkg::DOP_F4;   n_state = S_EXEC; end
            S_EXEC: begin
                o_cmd.op = c8ic_pkg::DOP_EXEC;
                case (i_stat.cls)
                    c8ic_pkg::CL_FLAG: n_state = S_VF;
                    c8ic_pkg::CL_DRAW: n_state = i_stat.rows_zero ? S_VF : S_D0;
                    c8ic_pkg::CL_BCD:  n_state = S_B0;
                    c8ic_pkg::CL_SAVE: n_state = S_SR;
                    c8ic_pkg::CL_LOAD: n_state = S_LR;
                    default:           n_state = S_FIN;
                endcase
            end
            S_VF:   begin o_cmd.op = c8ic_pkg::DOP_VF; n_state = S_FIN; end
            S_D0:   begin o_cmd.op = c8ic_pkg::DOP_D0; n_state = S_D1; end
            S_D1:   begin o_cmd.op = c8ic_pkg::DOP_D1; n_state = S_D2; end
            S_D2:   begin o_cmd.op = c8ic_pkg::DOP_D2; n_state = S_D3; end
            S_D3: begin
                o_cmd.op = c8ic_pkg::DOP_D3;
                n_state  = i_stat.last_row ? S_VF : S_D0;
            end
            S_B0:   begin o_cmd.op = c8ic_pkg::DOP_B0; n_state = S_B1; end
            S_B1:   begin o_cmd.op = c8ic_pkg::DOP_B1; n_state = S_B2; end
            S_B2:   begin o_cmd.op = c8ic_pkg::DOP_B2; n_state = S_FIN; end
            S_SR:   begin o_cmd.op = c8ic_pkg::DOP_SR; n_state = S_SW; end
            S_SW: begin
                o_cmd.op = c8ic_pkg::DOP_SW;
                n_state  = i_stat.last_cnt ? S_FIN : S_SR;
            end
            S_LR:   begin o_cmd.op = c8ic_pkg::DOP_LR; n_state = S_LW; end
            S_LW: begin
                o_cmd.op = c8ic_pkg::DOP_LW;
                n_state  = i_stat.last_cnt ? S_FIN : S_LR;
            end
            S_FIN: begin
                o_cmd.op = c8ic_pkg::DOP_FIN;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/c8ic_dpath.sv */
module c8ic_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c8ic_pkg::t_cmd   i_cmd,
    input  logic             i_take,
    input  logic [1:0]       i_func,
    input  logic [11:0]      i_addr,
    input  logic [7:0]       i_wdata,
    input  logic [15:0]      i_keys,
    input  logic [7:0]       i_rand,
    output c8ic_pkg::t_stat  o_stat,
    c8ic_out_if.source       o_out
);

    // storage
    logic [7:0]   r_mem [4096];
    logic [7:0]   r_mrd;
    logic [7:0]   r_fb [256];
    logic [255:0] r_fbv;
    logic [7:0]   r_fbrd;
    logic         r_fbrv;
    logic [7:0]   r_v [16];
    logic [15:0]  r_vv;
    logic [7:0]   r_vrd;
    logic         r_vrv;
    logic [11:0]  r_stk [16];

    logic [11:0] r_pc, r_i, r_clr;
    logic [3:0]  r_sp, r_cnt;
    logic [7:0]  r_dt, r_st;
    logic [1:0]  r_func;
    logic [11:0] r_addr;
    logic [7:0]  r_wdata, r_rand, r_vx, r_vy, r_spr;
    logic [15:0] r_keys, r_op;
    logic        r_flag, r_wait, r_bad;

    logic        r_ovld;
    logic [7:0]  r_ordata;
    logic [11:0] r_opc;
    logic [15:0] r_oop;
    logic        r_owait, r_osnd, r_obad;

    // ports
    logic        m_we;
    logic [11:0] m_wa, m_ra;
    logic [7:0]  m_wd;
    logic        f_we;
    logic [7:0]  f_wa, f_ra, f_wd;
    logic        v_we;
    logic [3:0]  v_wa, v_ra;
    logic [7:0]  v_wd;

    logic [3:0]  x, y, nib;
    logic [7:0]  kk;
    logic [11:0] nnn, i_off;
    logic [7:0]  vrd_eff, fb_eff;
    logic [4:0]  py;
    logic [2:0]  col;
    logic [15:0] spr16;
    logic [7:0]  m0, m1;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_p;
    logic [3:0]  bcd_t, bcd_o;
    logic        key_hit, key_any;
    logic [3:0]  key_low;
    logic [8:0]  sum9;
    logic        ex_vwe, ex_fl;
    logic [7:0]  ex_vd;
    logic        out_free, tick;
    logic [7:0]  st_n, dt_n;

    assign x     = r_op[11:8];
    assign y     = r_op[7:4];
    assign nib   = r_op[3:0];
    assign kk    = r_op[7:0];
    assign nnn   = r_op[11:0];
    assign i_off = r_i + {8'h00, r_cnt};

    assign vrd_eff = r_vrv ? r_vrd : 8'h00;
    assign fb_eff  = r_fbrv ? r_fbrd : 8'h00;

    // sprite row: two frame bytes, wrapping at the right edge and bottom
    assign py    = r_vy[4:0] + {1'b0, r_cnt};
    assign col   = r_vx[5:3];
    assign spr16 = {r_spr, 8'h00} >> r_vx[2:0];
    assign m0    = spr16[15:8];
    assign m1    = spr16[7:0];

    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 2'd2;
        end else if (r_vx >= 8'd100) begin
            bcd_h = 2'd1;
        end else begin
            bcd_h = 2'd0;
        end
        bcd_rem = 7'(r_vx - 8'(bcd_h) * 8'd100);
        // x/10 = (x*205)>>11 holds for x below 100
        bcd_p   = 15'(bcd_rem) * 15'd205;
        bcd_t   = bcd_p[14:11];
        bcd_o   = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
    end

    always_comb begin
        key_low = 4'h0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) key_low = 4'(k);
        end
        key_any = |r_keys;
        key_hit = (r_vx[7:4] == 4'h0) && r_keys[r_vx[3:0]];
    end

    assign sum9 = {1'b0, r_vx} + {1'b0, r_vy};

    always_comb begin
        ex_vwe = 1'b0;
        ex_vd  = 8'h00;
        ex_fl  = 1'b0;
        case (r_op[15:12])
            c8ic_pkg::OP_LD:  begin ex_vwe = 1'b1; ex_vd = kk; end
            c8ic_pkg::OP_ADD: begin ex_vwe = 1'b1; ex_vd = r_vx + kk; end
            c8ic_pkg::OP_RND: begin ex_vwe = 1'b1; ex_vd = r_rand & kk; end
            c8ic_pkg::OP_ALU: begin
                case (nib)
                    c8ic_pkg::ALU_MOV: begin ex_vwe = 1'b1; ex_vd = r_vy; end
                    c8ic_pkg::ALU_OR:  begin ex_vwe = 1'b1; ex_vd = r_vx | r_vy; end
                    c8ic_pkg::ALU_AND: begin ex_vwe = 1'b1; ex_vd = r_vx & r_vy; end
                    c8ic_pkg::ALU_XOR: begin ex_vwe = 1'b1; ex_vd = r_vx ^ r_vy; end
                    c8ic_pkg::ALU_ADD: begin
                        ex_vwe = 1'b1; ex_vd = sum9[7:0]; ex_fl = sum9[8];
                    end
                    c8ic_pkg::ALU_SUB: begin
                        ex_vwe = 1'b1; ex_vd = r_vx - r_vy; ex_fl = (r_vx >= r_vy);
                    end
                    c8ic_pkg::ALU_SHR: begin
                        ex_vwe = 1'b1; ex_vd = {1'b0, r_vx[7:1]}; ex_fl = r_vx[0];
                    end
                    c8ic_pkg::ALU_SBN: begin
                        ex_vwe = 1'b1; ex_vd = r_vy - r_vx; ex_fl = (r_vy >= r_vx);
                    end
                    c8ic_pkg::ALU_SHL: begin
                        ex_vwe = 1'b1; ex_vd = {r_vx[6:0], 1'b0}; ex_fl = r_vx[7];
                    end
                    default: ex_vwe = 1'b0;
                endcase
            end
            c8ic_pkg::OP_MISC: begin
                if (kk == c8ic_pkg::FX_GDT) begin
                    ex_vwe = 1'b1; ex_vd = r_dt;
                end else if (kk == c8ic_pkg::FX_WKEY && key_any) begin
                    ex_vwe = 1'b1; ex_vd = {4'h0, key_low};
                end
            end
            default: ex_vwe = 1'b0;
        endcase
    end

    // memory port steering
    always_comb begin
        m_we = 1'b0; m_wa = r_addr; m_wd = r_wdata; m_ra = r_pc;
        f_we = 1'b0; f_wa = {py, col}; f_wd = 8'h00; f_ra = r_addr[7:0];
        v_we = 1'b0; v_wa = x; v_wd = ex_vd; v_ra = r_cnt;
        case (i_cmd.op)
            c8ic_pkg::DOP_CLR: begin
                m_we = 1'b1;
                m_wa = r_clr;
                m_wd = (r_clr < 12'(c8ic_pkg::C_FONT_BYTES)) ?
                       c8ic_pkg::f_font(r_clr[6:0]) : 8'h00;
            end
            c8ic_pkg::DOP_WR: m_we = 1'b1;
            c8ic_pkg::DOP_F0: m_ra = r_pc;
            c8ic_pkg::DOP_F1: m_ra = r_pc + 12'd1;
            c8ic_pkg::DOP_F2: v_ra = r_op[11:8];
            c8ic_pkg::DOP_F3: v_ra = (r_op[15:12] == c8ic_pkg::OP_JPV) ? 4'h0 : y;
            c8ic_pkg::DOP_EXEC: v_we = ex_vwe;
            c8ic_pkg::DOP_VF: begin
                v_we = 1'b1; v_wa = 4'hF; v_wd = {7'h00, r_flag};
            end
            c8ic_pkg::DOP_D0: m_ra = i_off;
            c8ic_pkg::DOP_D1: f_ra = {py, col};
            c8ic_pkg::DOP_D2: begin
                f_we = 1'b1; f_wa = {py, col}; f_wd = fb_eff ^ m0;
                f_ra = {py, 3'(col + 3'd1)};
            end
            c8ic_pkg::DOP_D3: begin
                f_we = 1'b1; f_wa = {py, 3'(col + 3'd1)}; f_wd = fb_eff ^ m1;
            end
            c8ic_pkg::DOP_B0: begin m_we = 1'b1; m_wa = r_i; m_wd = {6'h00, bcd_h}; end
            c8ic_pkg::DOP_B1: begin
                m_we = 1'b1; m_wa = r_i + 12'd1; m_wd = {4'h0, bcd_t};
            end
            c8ic_pkg::DOP_B2: begin
                m_we = 1'b1; m_wa = r_i + 12'd2; m_wd = {4'h0, bcd_o};
            end
            c8ic_pkg::DOP_SR: v_ra = r_cnt;
            c8ic_pkg::DOP_SW: begin m_we = 1'b1; m_wa = i_off; m_wd = vrd_eff; end
            c8ic_pkg::DOP_LR: m_ra = i_off;
            c8ic_pkg::DOP_LW: begin v_we = 1'b1; v_wa = r_cnt; v_wd = r_mrd; end
            default: m_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) r_mem[m_wa] <= m_wd;
        r_mrd <= r_mem[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) r_fb[f_wa] <= f_wd;
        r_fbrd <= r_fb[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_v[v_wa] <= v_wd;
        r_vrd <= r_v[v_ra];
    end

    assign out_free = !r_ovld || o_out.ready;
    assign tick     = (r_func == c8ic_pkg::FN_EXEC);
    assign st_n     = (tick && r_st != 8'h00) ? r_st - 8'd1 : r_st;
    assign dt_n     = (tick && r_dt != 8'h00) ? r_dt - 8'd1 : r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= c8ic_pkg::C_START_PC;
            r_i    <= 12'h000;
            r_sp   <= 4'h0;
            r_dt   <= 8'h00;
            r_st   <= 8'h00;
            r_clr  <= 12'h000;
            r_fbv  <= '0;
            r_vv   <= '0;
            r_fbrv <= 1'b0;
            r_vrv  <= 1'b0;
            r_ovld <= 1'b0;
            for (int k = 0; k < 16; k++) r_stk[k] <= 12'h000;
        end else begin
            r_fbrv <= r_fbv[f_ra];
            r_vrv  <= r_vv[v_ra];
            if (f_we) r_fbv[f_wa] <= 1'b1;
            if (v_we) r_vv[v_wa] <= 1'b1;
            if (i_cmd.op == c8ic_pkg::DOP_FIN && out_free) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && o_out.ready) begin
                r_ovld <= 1'b0;
            end

            case (i_cmd.op)
                c8ic_pkg::DOP_CLR: r_clr <= r_clr + 12'd1;
                c8ic_pkg::DOP_EXEC: begin
                    case (r_op[15:12])
                        c8ic_pkg::OP_SYS: begin
                            if (r_op == c8ic_pkg::SYS_CLS) begin
                                r_fbv <= '0;
                            end else if (r_op == c8ic_pkg::SYS_RET) begin
                                r_pc <= r_stk[r_sp];
                                r_sp <= r_sp - 4'd1;
                            end
                        end
                        c8ic_pkg::OP_JP: r_pc <= nnn;
                        c8ic_pkg::OP_CALL: begin
                            r_sp                 <= r_sp + 4'd1;
                            r_stk[r_sp + 4'd1]   <= r_pc;
                            r_pc                 <= nnn;
                        end
                        c8ic_pkg::OP_SE:   if (r_vx == kk)   r_pc <= r_pc + 12'd2;
                        c8ic_pkg::OP_SNE:  if (r_vx != kk)   r_pc <= r_pc + 12'd2;
                        c8ic_pkg::OP_SEV:  if (r_vx == r_vy) r_pc <= r_pc + 12'd2;
                        c8ic_pkg::OP_SNEV: if (r_vx != r_vy) r_pc <= r_pc + 12'd2;
                        c8ic_pkg::OP_LDI:  r_i  <= nnn;
                        c8ic_pkg::OP_JPV:  r_pc <= nnn + {4'h0, r_vy};
                        c8ic_pkg::OP_KEY: begin
                            if (kk == c8ic_pkg::KEY_SKP && key_hit) begin
                                r_pc <= r_pc + 12'd2;
                            end else if (kk == c8ic_pkg::KEY_SKNP && !key_hit) begin
                                r_pc <= r_pc + 12'd2;
                            end
                        end
                        c8ic_pkg::OP_MISC: begin
                            case (kk)
                                c8ic_pkg::FX_WKEY: if (!key_any) r_pc <= r_pc - 12'd2;
                                c8ic_pkg::FX_SDT:  r_dt <= r_vx;
                                c8ic_pkg::FX_SST:  r_st <= r_vx;
                                c8ic_pkg::FX_ADDI: r_i  <= r_i + {4'h0, r_vx};
                                c8ic_pkg::FX_FONT:
                                    r_i <= {6'h00, r_vx[3:0], 2'b00} + {8'h00, r_vx[3:0]};
                                default: r_i <= r_i;
                            endcase
                        end
                        default: r_pc <= r_pc;
                    endcase
                end
                c8ic_pkg::DOP_F2: r_pc <= r_pc + 12'd2;
                c8ic_pkg::DOP_FIN: begin
                    if (out_free) begin
                        r_dt   <= dt_n;
                        r_st   <= st_n;
                    end
                end
                default: r_clr <= r_clr;
            endcase
        end
    end

    // item payload and per-instruction scratch
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            c8ic_pkg::DOP_TAKE: begin
                if (i_take) begin
                    r_func  <= i_func;
                    r_addr  <= i_addr;
                    r_wdata <= i_wdata;
                    r_keys  <= i_keys;
                    r_rand  <= i_rand;
                    r_op    <= 16'h0000;
                    r_wait  <= 1'b0;
                    r_bad   <= 1'b0;
                end
            end
            c8ic_pkg::DOP_F1: r_op[15:8] <= r_mrd;
            c8ic_pkg::DOP_F2: r_op[7:0]  <= r_mrd;
            c8ic_pkg::DOP_F3: r_vx <= vrd_eff;
            c8ic_pkg::DOP_F4: r_vy <= vrd_eff;
            c8ic_pkg::DOP_EXEC: begin
                r_cnt  <= 4'h0;
                r_flag <= ex_fl;
                case (r_op[15:12])
                    c8ic_pkg::OP_SYS:
                        r_bad <= (r_op != c8ic_pkg::SYS_CLS) && (r_op != c8ic_pkg::SYS_RET);
                    c8ic_pkg::OP_ALU: r_bad <= !ex_vwe;
                    c8ic_pkg::OP_KEY:
                        r_bad <= (kk != c8ic_pkg::KEY_SKP) && (kk != c8ic_pkg::KEY_SKNP);
                    c8ic_pkg::OP_MISC: begin
                        r_wait <= (kk == c8ic_pkg::FX_WKEY) && !key_any;
                        r_bad  <= !(kk == c8ic_pkg::FX_GDT || kk == c8ic_pkg::FX_WKEY ||
                                    kk == c8ic_pkg::FX_SDT || kk == c8ic_pkg::FX_SST ||
                                    kk == c8ic_pkg::FX_ADDI || kk == c8ic_pkg::FX_FONT ||
                                    kk == c8ic_pkg::FX_BCD || kk == c8ic_pkg::FX_SAVE ||
                                    kk == c8ic_pkg::FX_LOAD);
                    end
                    default: r_bad <= 1'b0;
                endcase
            end
            c8ic_pkg::DOP_D1: r_spr <= r_mrd;
            c8ic_pkg::DOP_D2: r_flag <= r_flag | (|(fb_eff & m0));
            c8ic_pkg::DOP_D3: begin
                r_flag <= r_flag | (|(fb_eff & m1));
                r_cnt  <= r_cnt + 4'd1;
            end
            c8ic_pkg::DOP_SW: r_cnt <= r_cnt + 4'd1;
            c8ic_pkg::DOP_LW: r_cnt <= r_cnt + 4'd1;
            c8ic_pkg::DOP_FIN: begin
                if (out_free) begin
                    r_ordata <= (r_func == c8ic_pkg::FN_FBRD && r_addr[11:8] == 4'h0) ?
                                fb_eff : 8'h00;
                    r_opc    <= r_pc;
                    r_oop    <= r_op;
                    r_owait  <= r_wait;
                    r_osnd   <= (st_n != 8'h00);
                    r_obad   <= r_bad;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_stat.cls       = c8ic_pkg::f_cls(r_op);
    assign o_stat.rows_zero = (nib == 4'h0);
    assign o_stat.last_row  = ((r_cnt + 4'd1) == nib);
    assign o_stat.last_cnt  = (r_cnt == x);
    assign o_stat.clr_last  = (r_clr == 12'hFFF);
    assign o_stat.out_free  = out_free;

    assign o_out.valid       = r_ovld;
    assign o_out.rdata       = r_ordata;
    assign o_out.pc_now      = r_opc;
    assign o_out.opcode_done = r_oop;
    assign o_out.key_wait    = r_owait;
    assign o_out.sound_on    = r_osnd;
    assign o_out.bad_opcode  = r_obad;

endmodule

/* rtl/chip8_instruction_core_unit.sv */
// CHIP-8 core: one beat in, one result beat out. After reset the core loads the
// font and zeroes main memory before it accepts its first beat. A memory write
// or frame-buffer read is a single access; an instruction fetches two opcode
// bytes and reads two registers (each memory has one read port), executes, and
// then adds a flag write, a sprite-byte read and two frame-byte updates per
// sprite row plus the flag write for a draw, the BCD digit writes, or a read and
// a write per register for block save and restore (worst case a 15-row draw).
// The result waits in an output register; the next beat is taken once idle.
`include "assert_macros.svh"

module chip8_instruction_core_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    c8ic_in_if.sink      i_in,
    c8ic_out_if.source   o_out
);

    c8ic_pkg::t_cmd  cmd;
    c8ic_pkg::t_stat stat;
    logic            in_ready;
    logic            take;
    logic            out_is_wait_op;

    assign i_in.ready = in_ready;
    assign take       = i_in.valid && in_ready;

    assign out_is_wait_op = (o_out.opcode_done[15:12] == c8ic_pkg::OP_MISC) &&
                            (o_out.opcode_done[7:0] == c8ic_pkg::FX_WKEY);

    c8ic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    c8ic_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_take  (take),
        .i_func  (i_in.func),
        .i_addr  (i_in.addr),
        .i_wdata (i_in.wdata),
        .i_keys  (i_in.keys),
        .i_rand  (i_in.rand_byte),
        .o_stat  (stat),
        .o_out   (o_out)
    );

    `C8_ASSERT(a_one_beat, take |=> !i_in.ready, "core took a second beat while busy")
    `C8_ASSERT(a_wait_op, (o_out.valid && o_out.key_wait) |-> out_is_wait_op, "bad key wait")
    `C8_ASSERT(a_rd_noop, (o_out.valid && o_out.rdata != 8'h00) |-> (o_out.opcode_done == 16'h0000), "read data on an executed instruction")
    `C8_ASSERT_ALL(a_rst_out, !i_rst_n |=> !o_out.valid, "result valid right after reset")

endmodule
